FILE: hdl/windowed_rms_meter_defines.svh
// Assertion macros for the windowed RMS meter.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef WINDOWED_RMS_METER_DEFINES_SVH
`define WINDOWED_RMS_METER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define WRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define WRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/wrm_pkg.sv
// Shared widths, reset values, register indexes and queue entry type
// for the windowed RMS meter. No dependencies.
`default_nettype none

package wrm_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 8;

    localparam int ACC_BITS      = 30;
    localparam int WIN_BITS      = 8;
    localparam int GAIN_BITS     = 20;
    localparam int FRAC_BITS     = 16;
    localparam int DIVIDEND_BITS = ACC_BITS + FRAC_BITS;
    localparam int ROOT_BITS     = DIVIDEND_BITS / 2;
    localparam int SREM_BITS     = ROOT_BITS + 2;
    localparam int PROD_BITS     = ROOT_BITS + GAIN_BITS;
    localparam int RMS_BITS      = 23;
    localparam int STEP_BITS     = $clog2(DIVIDEND_BITS + 1);

    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOLTS_GAIN    = CFG_INDEX_BITS'(1);

    localparam logic [WIN_BITS-1:0]  WINDOW_RESET = WIN_BITS'(200);
    localparam logic [GAIN_BITS-1:0] GAIN_RESET   = GAIN_BITS'(93240);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ACC_BITS-1:0] sum;
        logic [WIN_BITS-1:0] divisor;
    } wrm_entry_t;

endpackage

`default_nettype wire

FILE: hdl/windowed_rms_meter.sv
// Windowed RMS meter. Takes one sample per cycle while not stalled; squares and
// accumulates in the front. The last sample of a window enters a two-entry queue; the
// back end takes one window at a time through a pop, 46 divide steps, 23 root steps,
// a multiply and an output load. Short windows make the back end the bottleneck and
// the input stalls once the queue fills.
// Async active-low reset clears sum, count, queue and out_valid; window 200, gain 93240.
`default_nettype none

module windowed_rms_meter #(
    parameter int SAMPLE_BITS = wrm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = wrm_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [wrm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [wrm_pkg::GAIN_BITS-1:0]         cfg_data,
    input  wire logic                                  in_valid,
    output      logic                                  in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]         sample,
    output      logic                                  out_valid,
    input  wire logic                                  out_stall,
    output      logic [wrm_pkg::ACC_BITS-1:0]          sum_of_squares,
    output      logic [wrm_pkg::RMS_BITS-1:0]          rms_volts_q8
);

    logic [wrm_pkg::WIN_BITS-1:0]  window_length_reg, window_length_next;
    logic [wrm_pkg::GAIN_BITS-1:0] gain_reg, gain_next;

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_not_empty;
    wrm_pkg::wrm_entry_t  q_in;
    wrm_pkg::wrm_entry_t  q_out;

    always_comb
    begin
        window_length_next = window_length_reg;
        gain_next          = gain_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                wrm_pkg::REG_WINDOW_LENGTH: window_length_next = cfg_data[wrm_pkg::WIN_BITS-1:0];
                wrm_pkg::REG_VOLTS_GAIN:    gain_next          = cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= wrm_pkg::WINDOW_RESET;
            gain_reg          <= wrm_pkg::GAIN_RESET;
        end
        else
        begin
            window_length_reg <= window_length_next;
            gain_reg          <= gain_next;
        end
    end

    wrm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .window_length (window_length_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_in)
    );

    wrm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .not_empty  (q_not_empty)
    );

    wrm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_entry        (q_out),
        .q_pop          (q_pop),
        .volts_gain_q16 (gain_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sum_of_squares (sum_of_squares),
        .rms_volts_q8   (rms_volts_q8)
    );

endmodule

`default_nettype wire

FILE: hdl/wrm_front.sv
// Front end: squares samples, accumulates and counts, and hands each
// finished window to the queue. Depends on wrm_pkg.
`default_nettype none

module wrm_front #(
    parameter int SAMPLE_BITS = wrm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = wrm_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]   sample,
    input  wire logic [wrm_pkg::WIN_BITS-1:0]    window_length,
    input  wire logic                            q_full,
    output      logic                            q_push,
    output      wrm_pkg::wrm_entry_t             q_entry
);

    localparam int SQ_BITS = 2 * SAMPLE_BITS;

    logic [wrm_pkg::ACC_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0]        cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0]       mag;
    logic [SQ_BITS-1:0]           square;
    logic [wrm_pkg::ACC_BITS-1:0] acc_sum;
    logic [COUNT_BITS-1:0]        cnt_inc;
    logic                         accept;
    logic                         window_end;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // The most negative code maps to 2^(SAMPLE_BITS-1), which still fits unsigned.
    assign mag     = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    assign square  = mag * mag;
    assign acc_sum = acc_reg + wrm_pkg::ACC_BITS'(square);
    assign cnt_inc = cnt_reg + COUNT_BITS'(1);

    assign window_end = wrm_pkg::WIN_BITS'(cnt_inc) >= window_length;

    assign q_push          = accept && window_end;
    assign q_entry.sum     = acc_sum;
    assign q_entry.divisor = (window_length != '0) ? window_length
                                                   : wrm_pkg::WIN_BITS'(1);

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            acc_next = window_end ? '0 : acc_sum;
            cnt_next = window_end ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wrm_queue.sv
// Two-entry queue between the accumulate front and the divide/sqrt back.
// Depends on wrm_pkg and the assertion macro header.
`default_nettype none
`include "windowed_rms_meter_defines.svh"

module wrm_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire wrm_pkg::wrm_entry_t   push_entry,
    output      logic                  full,
    input  wire logic                  pop,
    output      wrm_pkg::wrm_entry_t   pop_entry,
    output      logic                  not_empty
);

    wrm_pkg::wrm_entry_t                 slot_reg [wrm_pkg::QUEUE_DEPTH];
    logic [wrm_pkg::QPTR_BITS-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [wrm_pkg::QPTR_BITS-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [wrm_pkg::QCNT_BITS-1:0]       count_reg, count_next;

    assign full      = count_reg == wrm_pkg::QCNT_BITS'(wrm_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == wrm_pkg::QPTR_BITS'(wrm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + wrm_pkg::QPTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == wrm_pkg::QPTR_BITS'(wrm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + wrm_pkg::QPTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + wrm_pkg::QCNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - wrm_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `WRM_ASSERT_NOW(a_no_push_full, full, !push, "queue pushed while full")
    `WRM_ASSERT_NOW(a_no_pop_empty, pop, not_empty, "queue popped while empty")
    `WRM_ASSERT_NEXT(a_count_track, push && !pop && !full,
                     count_reg == $past(count_reg) + wrm_pkg::QCNT_BITS'(1),
                     "queue count lost a push")

endmodule

`default_nettype wire

FILE: hdl/wrm_back.sv
// Back end: restoring divide by the window length, bit-pair integer
// square root, gain multiply and output register. Depends on wrm_pkg.
`default_nettype none
`include "windowed_rms_meter_defines.svh"

module wrm_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_not_empty,
    input  wire wrm_pkg::wrm_entry_t               q_entry,
    output      logic                              q_pop,
    input  wire logic [wrm_pkg::GAIN_BITS-1:0]     volts_gain_q16,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [wrm_pkg::ACC_BITS-1:0]      sum_of_squares,
    output      logic [wrm_pkg::RMS_BITS-1:0]      rms_volts_q8
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int DB = wrm_pkg::DIVIDEND_BITS;
    localparam int WB = wrm_pkg::WIN_BITS;
    localparam int RB = wrm_pkg::ROOT_BITS;
    localparam int SB = wrm_pkg::SREM_BITS;

    logic [2:0]                        state_reg, state_next;
    logic [wrm_pkg::STEP_BITS-1:0]     step_reg, step_next;
    logic [DB-1:0]                     work_reg, work_next;
    logic [WB-1:0]                     rem_reg, rem_next;
    logic [WB-1:0]                     div_reg, div_next;
    logic [SB-1:0]                     srem_reg, srem_next;
    logic [RB-1:0]                     root_reg, root_next;
    logic [wrm_pkg::ACC_BITS-1:0]      sum_reg, sum_next;
    logic [wrm_pkg::PROD_BITS-1:0]     prod_reg, prod_next;
    logic                              out_valid_reg, out_valid_next;
    logic [wrm_pkg::ACC_BITS-1:0]      out_sum_reg, out_sum_next;
    logic [wrm_pkg::RMS_BITS-1:0]      out_rms_reg, out_rms_next;

    logic [WB:0]   div_trial;
    logic          div_ge;
    logic [SB+1:0] sq_shift;
    logic [SB+1:0] sq_trial;
    logic          sq_ge;
    logic          out_free;

    assign div_trial = {rem_reg, work_reg[DB-1]};
    assign div_ge    = div_trial >= {1'b0, div_reg};

    assign sq_shift = {srem_reg, work_reg[DB-1 -: 2]};
    assign sq_trial = (SB + 2)'({root_reg, 2'b01});
    assign sq_ge    = sq_shift >= sq_trial;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        out_sum_next   = out_sum_reg;
        out_rms_next   = out_rms_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    sum_next   = q_entry.sum;
                    div_next   = q_entry.divisor;
                    work_next  = {q_entry.sum, wrm_pkg::FRAC_BITS'(0)};
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, MSB first
                rem_next  = div_ge ? WB'(div_trial - {1'b0, div_reg}) : div_trial[WB-1:0];
                work_next = {work_reg[DB-2:0], div_ge};
                step_next = step_reg + wrm_pkg::STEP_BITS'(1);
                if (step_reg == wrm_pkg::STEP_BITS'(DB - 1))
                begin
                    step_next  = '0;
                    srem_next  = '0;
                    root_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // one root bit per cycle from two radicand bits
                srem_next = sq_ge ? SB'(sq_shift - sq_trial) : SB'(sq_shift);
                root_next = {root_reg[RB-2:0], sq_ge};
                work_next = {work_reg[DB-3:0], 2'b00};
                step_next = step_reg + wrm_pkg::STEP_BITS'(1);
                if (step_reg == wrm_pkg::STEP_BITS'(RB - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = root_reg * volts_gain_q16;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = sum_reg;
                    out_rms_next   = prod_reg[wrm_pkg::FRAC_BITS +: wrm_pkg::RMS_BITS];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        sum_reg     <= sum_next;
        prod_reg    <= prod_next;
        out_sum_reg <= out_sum_next;
        out_rms_reg <= out_rms_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sum_of_squares = out_sum_reg;
    assign rms_volts_q8   = out_rms_reg;

    `WRM_ASSERT_NOW(a_div_rem_bound, state_reg == ST_DIV, rem_reg < div_reg,
                    "divide remainder not below divisor")
    `WRM_ASSERT_NEXT(a_pop_starts_div, q_pop, state_reg == ST_DIV,
                     "popped window did not start divide")

endmodule

`default_nettype wire

FILE: test/windowed_rms_meter_tb.sv
// Self-checking testbench for the windowed RMS meter: drives samples and register writes,
// predicts each window's sum of squares and RMS value, and checks every result word.
// Depends on wrm_pkg and windowed_rms_meter only.
`timescale 1ns / 100ps

module windowed_rms_meter_tb;

    localparam int SAMPLE_W = wrm_pkg::SAMPLE_BITS_DEF;
    localparam int COUNT_W  = wrm_pkg::COUNT_BITS_DEF;

    // Indexes the block decodes to nothing.
    localparam logic [wrm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO =
        wrm_pkg::CFG_INDEX_BITS'(2);
    localparam logic [wrm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI =
        wrm_pkg::CFG_INDEX_BITS'(3);

    localparam logic [wrm_pkg::GAIN_BITS-1:0] GAIN_MAX = '1;
    localparam int SETTLE_CYCLES = 150;
    localparam int MAX_PRINTED   = 50;

    typedef struct {
        logic [wrm_pkg::ACC_BITS-1:0] sum;
        logic [wrm_pkg::RMS_BITS-1:0] rms;
    } rms_result_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_we = 1'b0;
    logic [wrm_pkg::CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [wrm_pkg::GAIN_BITS-1:0]         cfg_data = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic signed [SAMPLE_W-1:0]            sample = '0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic [wrm_pkg::ACC_BITS-1:0]          sum_of_squares;
    logic [wrm_pkg::RMS_BITS-1:0]          rms_volts_q8;

    // Predictor state and its copy of the registers.
    logic [wrm_pkg::ACC_BITS-1:0]  square_sum   = '0;
    logic [COUNT_W-1:0]            window_count = '0;
    logic [wrm_pkg::WIN_BITS-1:0]  win_len_cfg  = wrm_pkg::WINDOW_RESET;
    logic [wrm_pkg::GAIN_BITS-1:0] gain_cfg     = wrm_pkg::GAIN_RESET;

    rms_result_t rms_results_due[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;

    windowed_rms_meter #(
        .SAMPLE_BITS (SAMPLE_W),
        .COUNT_BITS  (COUNT_W)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sum_of_squares (sum_of_squares),
        .rms_volts_q8   (rms_volts_q8)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Integer square root, one result bit at a time from the top.
    function automatic longint unsigned floor_sqrt(input longint unsigned value);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 23; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value)
                root = trial;
        end
        return root;
    endfunction

    task automatic account_sample(input logic signed [SAMPLE_W-1:0] value);
        int              level;
        longint unsigned divisor;
        longint unsigned mean_sq;
        longint unsigned scaled;
        rms_result_t     due;
        level = value;
        if (level < 0)
            level = -level;
        square_sum   = square_sum + wrm_pkg::ACC_BITS'(level * level);
        window_count = window_count + 1'b1;
        if (window_count >= win_len_cfg)
        begin
            divisor = (win_len_cfg == 0) ? 1 : win_len_cfg;
            mean_sq = (longint'(square_sum) << wrm_pkg::FRAC_BITS) / divisor;
            scaled  = (floor_sqrt(mean_sq) * gain_cfg) >> wrm_pkg::FRAC_BITS;
            due.sum = square_sum;
            due.rms = scaled[wrm_pkg::RMS_BITS-1:0];
            rms_results_due.push_back(due);
            square_sum   = '0;
            window_count = '0;
        end
    endtask

    // Receiver: a requested hold-off wins over the random stall.
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_stall     <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        rms_result_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rms_results_due.size() == 0)
                report_mismatch($sformatf("unexpected word sum=%0d rms=%0d",
                                          sum_of_squares, rms_volts_q8));
            else
            begin
                due = rms_results_due.pop_front();
                if (sum_of_squares !== due.sum)
                    report_mismatch($sformatf("sum_of_squares %0d, want %0d",
                                              sum_of_squares, due.sum));
                if (rms_volts_q8 !== due.rms)
                    report_mismatch($sformatf("rms_volts_q8 %0d, want %0d",
                                              rms_volts_q8, due.rms));
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= value;
        // hold the word until the block takes it
        do
            @(posedge clk);
        while (in_stall);
        account_sample(value);
    endtask

    task automatic write_reg(input logic [wrm_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [wrm_pkg::GAIN_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            wrm_pkg::REG_WINDOW_LENGTH: win_len_cfg = data[wrm_pkg::WIN_BITS-1:0];
            wrm_pkg::REG_VOLTS_GAIN:    gain_cfg = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every pending result, then let the back end go quiet.
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rms_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic pick_random_config();
        int                            pick;
        logic [wrm_pkg::WIN_BITS-1:0]  win;
        logic [wrm_pkg::GAIN_BITS-1:0] gain;
        pick = $urandom_range(9);
        if (pick < 7)
            win = wrm_pkg::WIN_BITS'($urandom_range(1, 12));
        else if (pick == 7)
            win = '0;
        else if (pick == 8)
            win = '1;
        else
            win = wrm_pkg::WIN_BITS'($urandom_range(1, 255));
        case ($urandom_range(4))
            0:       gain = '0;
            1:       gain = GAIN_MAX;
            default: gain = wrm_pkg::GAIN_BITS'($urandom);
        endcase
        // upper data bits are don't-care for the window register
        write_reg(wrm_pkg::REG_WINDOW_LENGTH,
                  {(wrm_pkg::GAIN_BITS-wrm_pkg::WIN_BITS)'($urandom), win});
        write_reg(wrm_pkg::REG_VOLTS_GAIN, gain);
    endtask

    task automatic test_reset_config();
        repeat (400) send_sample(rand_sample());
        settle_idle();
    endtask

    task automatic test_corner_samples();
        write_reg(wrm_pkg::REG_WINDOW_LENGTH, wrm_pkg::GAIN_BITS'(1));
        write_reg(wrm_pkg::REG_VOLTS_GAIN, GAIN_MAX);
        send_sample(12'sh800);
        send_sample(12'sh7FF);
        send_sample(12'sh000);
        send_sample(12'shFFF);
        send_sample(12'sh001);
        send_sample(12'sh555);
        send_sample(12'shAAA);
        settle_idle();
        // zero window: every sample closes its own window
        write_reg(wrm_pkg::REG_WINDOW_LENGTH, wrm_pkg::GAIN_BITS'(0));
        send_sample(12'sh800);
        send_sample(12'sh7FF);
        settle_idle();
        write_reg(REG_SPARE_LO, wrm_pkg::GAIN_BITS'($urandom));
        write_reg(REG_SPARE_HI, wrm_pkg::GAIN_BITS'($urandom));
        write_reg(wrm_pkg::REG_WINDOW_LENGTH, wrm_pkg::GAIN_BITS'(2));
        write_reg(wrm_pkg::REG_VOLTS_GAIN, '0);
        send_sample(12'sh7FF);
        send_sample(12'sh800);
        settle_idle();
        write_reg(wrm_pkg::REG_WINDOW_LENGTH, {12'hABC, 8'd3});
        write_reg(wrm_pkg::REG_VOLTS_GAIN, wrm_pkg::GAIN_RESET);
        repeat (3) send_sample(12'sh800);
        settle_idle();
    endtask

    task automatic test_full_window();
        write_reg(wrm_pkg::REG_WINDOW_LENGTH, wrm_pkg::GAIN_BITS'(255));
        write_reg(wrm_pkg::REG_VOLTS_GAIN, GAIN_MAX);
        repeat (255) send_sample(12'sh800);
        settle_idle();
    endtask

    task automatic test_random_phases();
        int send_modes[4] = '{0, 79, 0, 29};
        int recv_modes[4] = '{0, 0, 79, 29};
        for (int m = 0; m < 4; m++)
        begin
            send_idle_pct  = send_modes[m];
            recv_stall_pct = recv_modes[m];
            repeat (2)
            begin
                pick_random_config();
                repeat (70) send_sample(rand_sample());
                settle_idle();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_output_holdoff();
        write_reg(wrm_pkg::REG_WINDOW_LENGTH, wrm_pkg::GAIN_BITS'(1));
        write_reg(wrm_pkg::REG_VOLTS_GAIN, wrm_pkg::GAIN_BITS'($urandom));
        @(posedge clk);
        hold_off_left = 400;
        repeat (40) send_sample(rand_sample());
        settle_idle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_config();
        test_corner_samples();
        test_full_window();
        test_random_phases();
        test_output_holdoff();
        settle_idle();
        if (mismatch_count == 0 && rms_results_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
